[rtl/core/hbs_pkg.sv]
// ----------------------------------------------------------------------------
// hbs_pkg
// shared constants, register codes and control types of the height map sampler
// ----------------------------------------------------------------------------
package hbs_pkg;

    // defaults for the top level parameters
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_LENGTH_DEF = 256;
    localparam int FRAC_BITS_DEF  = 8;

    // fraction bits of the result
    localparam int OUT_FRAC = 8;

    // reset value of both size registers (clamped to the store size)
    localparam int REG_RESET = 256;

    // queue depths, powers of two
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    // fixed field widths
    localparam int CFG_W    = 9;
    localparam int COORD_W  = 8;
    localparam int HEIGHT_W = 8;
    localparam int POS_W    = 17;
    localparam int VALUE_W  = 16;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // register indexes
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_LENGTH = 1'b1;

    // classification of one item, front to back
    typedef struct packed {
        logic is_query;
        logic out_of_range;
        logic clamp_x;
        logic clamp_z;
        logic load_ok;
    } hbs_ctl_t;

    // one result item
    typedef struct packed {
        logic                out_of_range;
        logic [VALUE_W-1:0]  height_value;
    } hbs_res_t;

endpackage

[rtl/core/heightmap_bilinear_sampler.sv]
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// 8-bit height map store with bilinear sampling at fixed-point positions
// ----------------------------------------------------------------------------
// A load item writes one height at (load_column, load_row); a query item
// returns the bilinear blend of the four heights around (query_x, query_z),
// with 8 fraction bits and halves rounded up, or zero with out_of_range set
// when the point is off the map. The block takes one item per clock unless a
// query waits for result queue room: each query reads its four neighbours at
// once from four memory banks split by column and row parity, so a query
// never waits on a port. Queries pass the bank read registers and stage two;
// a load transfer produces no result. The input queue holds four items and
// the result queue four results; queries are issued to the pipeline only
// when the result queue has room for them, so a stalled consumer backs up
// into the input queue and raises full. The right and upper neighbours are
// clamped to the last column and row in use. Heights never written read as
// unknown. There is no clearing pass after reset. The user must write the
// size registers only while the block is idle; the block doesn't enforce it.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler
    import hbs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write port
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    // input items
    input  logic                      push,
    output logic                      full,
    input  logic                      kind,
    input  logic [COORD_W-1:0]        load_column,
    input  logic [COORD_W-1:0]        load_row,
    input  logic [HEIGHT_W-1:0]       load_height,
    input  logic signed [POS_W-1:0]   query_x,
    input  logic signed [POS_W-1:0]   query_z,
    // result items
    output logic                      empty,
    input  logic                      pop,
    output logic [VALUE_W-1:0]        height_value,
    output logic                      out_of_range
);

    localparam int CBITS = $clog2(MAX_WIDTH);
    localparam int RBITS = $clog2(MAX_LENGTH);
    localparam int CMD_W = $bits(hbs_ctl_t) + CBITS + RBITS + 2 * FRAC_BITS + HEIGHT_W;
    localparam int RES_W = $bits(hbs_res_t);

    // front side, classified item
    hbs_ctl_t               f_ctl;
    logic [CBITS-1:0]       f_ix;
    logic [RBITS-1:0]       f_iz;
    logic [FRAC_BITS-1:0]   f_fx, f_fz;
    logic [HEIGHT_W-1:0]    f_height;

    // back side, head of the item queue
    hbs_ctl_t               c_ctl;
    logic [CBITS-1:0]       c_ix;
    logic [RBITS-1:0]       c_iz;
    logic [FRAC_BITS-1:0]   c_fx, c_fz;
    logic [HEIGHT_W-1:0]    c_height;

    logic [CMD_W-1:0]       cmd_in, cmd_out;
    logic                   cmd_empty;
    logic                   cmd_pop;

    logic                   res_push;
    hbs_res_t               res_data;
    hbs_res_t               res_head;
    logic [$clog2(RES_DEPTH):0] res_count;

    // range check, cell split and clamp flags, plus the size registers
    hbs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_LENGTH (MAX_LENGTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .load_column (load_column),
        .load_row    (load_row),
        .load_height (load_height),
        .query_x     (query_x),
        .query_z     (query_z),
        .ctl         (f_ctl),
        .ix          (f_ix),
        .iz          (f_iz),
        .fx          (f_fx),
        .fz          (f_fz),
        .ld_height   (f_height)
    );

    assign cmd_in = {f_ctl, f_ix, f_iz, f_fx, f_fz, f_height};

    // decoupling queue between classification and the store
    hbs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .full      (full),
        .empty     (cmd_empty),
        .count     ()
    );

    assign {c_ctl, c_ix, c_iz, c_fx, c_fz, c_height} = cmd_out;

    // banked store, neighbour fetch and blend
    hbs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_LENGTH (MAX_LENGTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_ctl    (c_ctl),
        .cmd_ix     (c_ix),
        .cmd_iz     (c_iz),
        .cmd_fx     (c_fx),
        .cmd_fz     (c_fz),
        .cmd_height (c_height),
        .cmd_pop    (cmd_pop),
        .res_count  (res_count),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    // result queue, never overflows since the back end holds credits
    hbs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .pop       (pop),
        .pop_data  (res_head),
        .full      (),
        .empty     (empty),
        .count     (res_count)
    );

    assign height_value = res_head.height_value;
    assign out_of_range = res_head.out_of_range;

endmodule

[rtl/core/hbs_fifo.sv]
// ----------------------------------------------------------------------------
// hbs_fifo
// small register queue with occupancy count, depth a power of two
// ----------------------------------------------------------------------------
module hbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH):0]     count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{AW{1'b0}}, do_push} - {{AW{1'b0}}, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/hbs_front.sv]
// ----------------------------------------------------------------------------
// hbs_front
// size registers and item classification: range check, cell, fraction, clamps
// ----------------------------------------------------------------------------
module hbs_front
    import hbs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [CFG_W-1:0]                cfg_data,
    input  logic                            kind,
    input  logic [COORD_W-1:0]              load_column,
    input  logic [COORD_W-1:0]              load_row,
    input  logic [HEIGHT_W-1:0]             load_height,
    input  logic signed [POS_W-1:0]         query_x,
    input  logic signed [POS_W-1:0]         query_z,
    output hbs_ctl_t                        ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]    ix,
    output logic [$clog2(MAX_LENGTH)-1:0]   iz,
    output logic [FRAC_BITS-1:0]            fx,
    output logic [FRAC_BITS-1:0]            fz,
    output logic [HEIGHT_W-1:0]             ld_height
);

    localparam int CBITS = $clog2(MAX_WIDTH);
    localparam int RBITS = $clog2(MAX_LENGTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int LB    = $clog2(MAX_LENGTH + 1);
    localparam int W_RST = (REG_RESET > MAX_WIDTH) ? MAX_WIDTH : REG_RESET;
    localparam int L_RST = (REG_RESET > MAX_LENGTH) ? MAX_LENGTH : REG_RESET;

    logic [WB-1:0] map_width_reg, map_width_next;
    logic [LB-1:0] map_length_reg, map_length_next;
    logic [31:0]   xw, zw, colw, roww;
    logic          x_in, z_in;

    // size registers, values above the store size act as the store size
    always_comb
    begin
        map_width_next  = map_width_reg;
        map_length_next = map_length_reg;
        if (cfg_we && cfg_index == REG_MAP_WIDTH)
        begin
            map_width_next = (32'(cfg_data) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(cfg_data);
        end
        if (cfg_we && cfg_index == REG_MAP_LENGTH)
        begin
            map_length_next = (32'(cfg_data) > MAX_LENGTH) ? LB'(MAX_LENGTH) : LB'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= WB'(W_RST);
            map_length_reg <= LB'(L_RST);
        end
        else
        begin
            map_width_reg  <= map_width_next;
            map_length_reg <= map_length_next;
        end
    end

    // whole cell of the position, sign bit checked apart
    always_comb
    begin
        xw   = 32'(query_x[POS_W-2:0]) >> FRAC_BITS;
        zw   = 32'(query_z[POS_W-2:0]) >> FRAC_BITS;
        colw = 32'(load_column);
        roww = 32'(load_row);
        x_in = !query_x[POS_W-1] && (xw < 32'(map_width_reg));
        z_in = !query_z[POS_W-1] && (zw < 32'(map_length_reg));

        ctl.is_query     = (kind == KIND_QUERY);
        ctl.out_of_range = !(x_in && z_in);
        ctl.clamp_x      = ((xw + 32'd1) >= 32'(map_width_reg));
        ctl.clamp_z      = ((zw + 32'd1) >= 32'(map_length_reg));
        ctl.load_ok      = (colw < 32'(MAX_WIDTH)) && (roww < 32'(MAX_LENGTH));

        ix        = (kind == KIND_QUERY) ? xw[CBITS-1:0] : colw[CBITS-1:0];
        iz        = (kind == KIND_QUERY) ? zw[RBITS-1:0] : roww[RBITS-1:0];
        fx        = query_x[FRAC_BITS-1:0];
        fz        = query_z[FRAC_BITS-1:0];
        ld_height = load_height;
    end

endmodule

[rtl/core/hbs_back.sv]
// ----------------------------------------------------------------------------
// hbs_back
// four parity banks of the height store and the two-stage blend pipeline
// ----------------------------------------------------------------------------
module hbs_back
    import hbs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_empty,
    input  hbs_ctl_t                        cmd_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]    cmd_ix,
    input  logic [$clog2(MAX_LENGTH)-1:0]   cmd_iz,
    input  logic [FRAC_BITS-1:0]            cmd_fx,
    input  logic [FRAC_BITS-1:0]            cmd_fz,
    input  logic [HEIGHT_W-1:0]             cmd_height,
    output logic                            cmd_pop,
    input  logic [$clog2(RES_DEPTH):0]      res_count,
    output logic                            res_push,
    output hbs_res_t                        res_data
);

    localparam int CBITS      = $clog2(MAX_WIDTH);
    localparam int RBITS      = $clog2(MAX_LENGTH);
    localparam int CHB        = (CBITS > 1) ? CBITS - 1 : 1;
    localparam int RHB        = (RBITS > 1) ? RBITS - 1 : 1;
    localparam int BAW        = CHB + RHB;
    localparam int BANK_DEPTH = 2 ** BAW;
    localparam int BOTW       = HEIGHT_W + FRAC_BITS;
    localparam int ACCW       = HEIGHT_W + 2 * FRAC_BITS;
    localparam int SH         = 2 * FRAC_BITS - OUT_FRAC;
    localparam int RND        = (SH > 0) ? (1 << (SH - 1)) : 0;
    localparam int CRW        = $clog2(RES_DEPTH) + 2;

    logic                  credit_ok;
    logic                  issue;
    logic                  rd_en;
    logic                  wr_en;
    logic [1:0]            wr_bank;
    logic [BAW-1:0]        wr_addr;
    logic [BAW-1:0]        rd_addr [4];
    logic [HEIGHT_W-1:0]   rd_q [4];
    logic [CBITS:0]        ixe, ixp;
    logic [RBITS:0]        ize, izp;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_oor_reg, s1_cx_reg, s1_cz_reg, s1_px_reg, s1_pz_reg;
    logic [FRAC_BITS-1:0]  s1_fx_reg, s1_fz_reg;

    logic                  s2_valid_reg, s2_valid_next;
    logic                  s2_oor_reg;
    logic [FRAC_BITS-1:0]  s2_fz_reg;
    logic [BOTW-1:0]       s2_bot_reg, s2_top_reg;

    logic [HEIGHT_W-1:0]   lb, rb, lt, rt, rb0, lt0, rt0, rt_x;
    logic [BOTW-1:0]       bot, top;
    logic [ACCW-1:0]       acc, acc_rnd;

    // a query issues only when the result queue has room for everything in flight
    assign credit_ok = (CRW'(res_count) + CRW'(s1_valid_reg) + CRW'(s2_valid_reg))
                       < CRW'(RES_DEPTH);
    assign issue     = !cmd_empty && (!cmd_ctl.is_query || credit_ok);
    assign cmd_pop   = issue;
    assign rd_en     = issue && cmd_ctl.is_query;
    assign wr_en     = issue && !cmd_ctl.is_query && cmd_ctl.load_ok;

    // even bank holds column ix or ix+1, whichever is even; same for rows
    always_comb
    begin
        ixe        = {1'b0, cmd_ix};
        ixp        = ixe + 1'b1;
        ize        = {1'b0, cmd_iz};
        izp        = ize + 1'b1;
        wr_bank    = {cmd_ix[0], cmd_iz[0]};
        wr_addr    = {ize[RHB:1], ixe[CHB:1]};
        rd_addr[0] = {izp[RHB:1], ixp[CHB:1]};
        rd_addr[1] = {ize[RHB:1], ixp[CHB:1]};
        rd_addr[2] = {izp[RHB:1], ixe[CHB:1]};
        rd_addr[3] = {ize[RHB:1], ixe[CHB:1]};
    end

    // bank index: column parity, row parity
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [HEIGHT_W-1:0] mem [BANK_DEPTH];
        logic [HEIGHT_W-1:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && wr_bank == 2'(b))
            begin
                mem[wr_addr] <= cmd_height;
            end
            if (rd_en)
            begin
                q_reg <= mem[rd_addr[b]];
            end
        end

        assign rd_q[b] = q_reg;
    end

    assign s1_valid_next = rd_en;
    assign s2_valid_next = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_oor_reg <= cmd_ctl.out_of_range;
            s1_cx_reg  <= cmd_ctl.clamp_x;
            s1_cz_reg  <= cmd_ctl.clamp_z;
            s1_px_reg  <= cmd_ix[0];
            s1_pz_reg  <= cmd_iz[0];
            s1_fx_reg  <= cmd_fx;
            s1_fz_reg  <= cmd_fz;
        end
        if (s1_valid_reg)
        begin
            s2_oor_reg <= s1_oor_reg;
            s2_fz_reg  <= s1_fz_reg;
            s2_bot_reg <= bot;
            s2_top_reg <= top;
        end
    end

    // neighbours, clamped ones replaced by their left or lower partner
    always_comb
    begin
        lb   = rd_q[{s1_px_reg, s1_pz_reg}];
        rb0  = rd_q[{~s1_px_reg, s1_pz_reg}];
        lt0  = rd_q[{s1_px_reg, ~s1_pz_reg}];
        rt0  = rd_q[{~s1_px_reg, ~s1_pz_reg}];
        rb   = s1_cx_reg ? lb : rb0;
        rt_x = s1_cx_reg ? lt0 : rt0;
        lt   = s1_cz_reg ? lb : lt0;
        rt   = s1_cz_reg ? rb : rt_x;
    end

    // a*(1-f) + b*f as a*one + (b-a)*f, modulo the width; the true value is non-negative
    always_comb
    begin
        bot = (BOTW'(lb) << FRAC_BITS) + (BOTW'(rb) - BOTW'(lb)) * BOTW'(s1_fx_reg);
        top = (BOTW'(lt) << FRAC_BITS) + (BOTW'(rt) - BOTW'(lt)) * BOTW'(s1_fx_reg);
    end

    always_comb
    begin
        acc = (ACCW'(s2_bot_reg) << FRAC_BITS)
              + (ACCW'(s2_top_reg) - ACCW'(s2_bot_reg)) * ACCW'(s2_fz_reg);
        acc_rnd = (acc + ACCW'(RND)) >> SH;
        res_push               = s2_valid_reg;
        res_data.out_of_range  = s2_oor_reg;
        res_data.height_value  = s2_oor_reg ? '0 : acc_rnd[VALUE_W-1:0];
    end

endmodule

[rtl/core/hbs_checker.sv]
// ----------------------------------------------------------------------------
// hbs_checker
// port-level checks of the height map sampler, bound to the top level
// ----------------------------------------------------------------------------
module hbs_checker
    import hbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic                 pop,
    input  logic                 empty,
    input  logic [VALUE_W-1:0]   height_value,
    input  logic                 out_of_range
);

    // off-map results carry a zero height
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_of_range |-> height_value == '0)
        else $error("out-of-range result with nonzero height");

    // a blend of 8-bit heights never exceeds 255.0
    a_value_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> height_value <= 16'hFF00)
        else $error("height above the largest sample");

    // a waiting result holds until its transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(height_value) && $stable(out_of_range))
        else $error("waiting result changed or vanished");

    // the input queue fills only by pushes
    a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
        !full && !push |=> !full)
        else $error("input queue became full without a push");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .pop          (pop),
    .empty        (empty),
    .height_value (height_value),
    .out_of_range (out_of_range)
);
